/* src/crt_pkg.sv */
// ----------------------------------------------------------------------------
// crt_pkg: shared types, constants and trig tables of the circle tessellator
// Fixed-point widths, the segment job word passed from front to back, the
// cos/sin boundary tables built at elaboration, and the saturating helpers.
// ----------------------------------------------------------------------------
package crt_pkg;

	localparam int SEGMENTS  = 36;
	localparam int COORD_W   = 24;
	localparam int RAD_W     = 23;
	localparam int PROG_W    = 18;
	localparam int PROG_FRAC = 16;
	localparam int VC_W      = 17;
	localparam int LIMIT_W   = 16;
	localparam int TRIG_W    = 17;
	localparam int IDX_W     = $clog2(SEGMENTS + 1);
	localparam int NRAW_W    = PROG_W + IDX_W - PROG_FRAC;
	localparam int PROD_W    = TRIG_W + RAD_W + 1;
	localparam int SUM_W     = COORD_W + 3;
	localparam int RND_SH    = 15;
	localparam int QUO_W     = PROD_W - RND_SH;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;
	localparam longint Q30_ONE = 64'sd1 <<< 30;

	typedef logic [SEGMENTS:0][TRIG_W-1:0] tab_t;

	// One drawn circle as handed to the segment engine
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] apex;
		logic [RAD_W-1:0]          fr;
		logic [RAD_W-1:0]          rad;
		logic [IDX_W-1:0]          n;
		logic                      fill;
		logic                      border;
	} job_t;

	// Quarter-turn phase to radians in Q30
	function automatic longint rad_q30(input longint r);
		return ((r & 64'sd16383) * 64'sd6746518852) >>> 16;
	endfunction

	// Sine in Q30 by truncating Horner steps, series to x^11
	function automatic longint sin_q30(input longint r);
		longint x, x2, t;
		x  = rad_q30(r);
		x2 = (x * x) >>> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 110;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
		if (t < 0) t = 0;
		return (x * t) >>> 30;
	endfunction

	// Cosine in Q30, series to x^12, each step floored at zero
	function automatic longint cos_q30(input longint r);
		longint x, x2, t;
		x  = rad_q30(r);
		x2 = (x * x) >>> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 132;
		if (t < 0) t = 0;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 90;
		if (t < 0) t = 0;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 56;
		if (t < 0) t = 0;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 30;
		if (t < 0) t = 0;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 12;
		if (t < 0) t = 0;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 2;
		if (t < 0) t = 0;
		return t;
	endfunction

	function automatic longint to_q15(input longint v);
		return (v + 64'sd16384) >>> 15;
	endfunction

	// Build the cos or sin value of every segment boundary
	function automatic tab_t build_tab(input bit want_sin);
		tab_t   tab;
		longint ph, q, r, sv, cv, c, s;
		tab = '0;
		for (int j = 0; j <= SEGMENTS; j++) begin
			ph = ((longint'(j) * 131072 + SEGMENTS) / (2 * SEGMENTS)) & 64'sd65535;
			q  = ph >>> 14;
			r  = ph & 64'sd16383;
			sv = to_q15(sin_q30(r));
			cv = to_q15(cos_q30(r));
			case (q)
				0: begin
					c = cv;
					s = sv;
				end
				1: begin
					c = -sv;
					s = cv;
				end
				2: begin
					c = -cv;
					s = -sv;
				end
				default: begin
					c = sv;
					s = -cv;
				end
			endcase
			tab[j] = want_sin ? TRIG_W'(s) : TRIG_W'(c);
		end
		return tab;
	endfunction

	localparam tab_t COS_TAB = build_tab(1'b0);
	localparam tab_t SIN_TAB = build_tab(1'b1);

	// Clamp a widened sum to the signed coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
		logic [SUM_W-COORD_W:0] top;
		top = v[SUM_W-1:COORD_W-1];
		if (top == '0 || top == '1) begin
			return v[COORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

	// Center plus rounded product, saturated
	function automatic logic signed [COORD_W-1:0] place(
		input logic signed [COORD_W-1:0] c,
		input logic signed [PROD_W-1:0]  p
	);
		logic signed [PROD_W-1:0] pr;
		logic [SUM_W-1:0]         sum;
		pr  = p + $signed(PROD_W'(16384));
		sum = {{(SUM_W-COORD_W){c[COORD_W-1]}}, c}
			+ {{(SUM_W-QUO_W){pr[PROD_W-1]}}, pr[PROD_W-1:RND_SH]};
		return sat_coord(sum);
	endfunction

endpackage

/* src/crt_ifs.sv */
// ----------------------------------------------------------------------------
// crt_ifs: channel interfaces of the circle tessellator
// Circle input, segment output and the vertex limit write channel.
// ----------------------------------------------------------------------------
interface crt_circle_if import crt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      frame_start;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic [RAD_W-1:0]          radius;
	logic [RAD_W-1:0]          ring_width;
	logic [PROG_W-1:0]         arc_progress;

	modport source (
		output valid, frame_start, center_x, center_y, radius, ring_width,
			arc_progress,
		input  ready
	);
	modport sink (
		input  valid, frame_start, center_x, center_y, radius, ring_width,
			arc_progress,
		output ready
	);
endinterface

interface crt_seg_if import crt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] fan_apex_x;
	logic signed [COORD_W-1:0] inner_x1;
	logic signed [COORD_W-1:0] inner_y1;
	logic signed [COORD_W-1:0] inner_x2;
	logic signed [COORD_W-1:0] inner_y2;
	logic signed [COORD_W-1:0] outer_x1;
	logic signed [COORD_W-1:0] outer_y1;
	logic signed [COORD_W-1:0] outer_x2;
	logic signed [COORD_W-1:0] outer_y2;
	logic                      has_fill;
	logic                      has_border;
	logic                      last;

	modport source (
		output valid, fan_apex_x, inner_x1, inner_y1, inner_x2, inner_y2,
			outer_x1, outer_y1, outer_x2, outer_y2, has_fill, has_border, last,
		input  ready
	);
	modport sink (
		input  valid, fan_apex_x, inner_x1, inner_y1, inner_x2, inner_y2,
			outer_x1, outer_y1, outer_x2, outer_y2, has_fill, has_border, last,
		output ready
	);
endinterface

interface crt_cfg_if import crt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* src/crt_front.sv */
// ----------------------------------------------------------------------------
// crt_front: circle intake and vertex budget
// Registers each circle, works out segment count and fill radius, applies
// the per-frame vertex budget and pushes drawn circles to the job queue.
// ----------------------------------------------------------------------------
module crt_front import crt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	crt_circle_if.sink circle,
	crt_cfg_if.sink    cfg,
	output logic       push_valid,
	input  logic       push_ready,
	output job_t       push_job
);

	logic                      valid_s1;
	logic                      fs_s1;
	logic signed [COORD_W-1:0] cx_s1;
	logic signed [COORD_W-1:0] cy_s1;
	logic [RAD_W-1:0]          rad_s1;
	logic [RAD_W-1:0]          bw_s1;
	logic [RAD_W-1:0]          fr_s1;
	logic [IDX_W-1:0]          n_s1;
	logic                      zero_s1;

	logic [VC_W-1:0]    vc_q;
	logic               stop_q;
	logic [LIMIT_W-1:0] limit_q;

	logic [PROG_W+IDX_W-1:0] prodp;
	logic [NRAW_W-1:0]       nraw;
	logic [IDX_W-1:0]        n_in;
	logic [RAD_W-1:0]        fr_in;

	logic [VC_W-1:0]  vc_eff, vc_a, vc_new, n3, n6, lim;
	logic             stop_eff, active, fill_want, border_want;
	logic             fill_fail, fill_ok, border_chk, border_fail, border_ok;
	logic             emit, ok;
	logic [SUM_W-1:0] apex_sum;

	// Segment count and fill radius at intake
	assign prodp = (PROG_W+IDX_W)'(SEGMENTS) * (PROG_W+IDX_W)'(circle.arc_progress);
	assign nraw  = prodp[PROG_W+IDX_W-1:PROG_FRAC];
	always_comb begin
		if (nraw > NRAW_W'(SEGMENTS)) begin
			n_in = IDX_W'(SEGMENTS);
		end else if (nraw == '0) begin
			n_in = IDX_W'(1);
		end else begin
			n_in = nraw[IDX_W-1:0];
		end
	end
	assign fr_in = (circle.radius > circle.ring_width) ?
		circle.radius - circle.ring_width : '0;

	// Budget check: fill first, then border
	assign vc_eff      = fs_s1 ? '0 : vc_q;
	assign stop_eff    = fs_s1 ? 1'b0 : stop_q;
	assign n3          = VC_W'(3) * VC_W'(n_s1);
	assign n6          = VC_W'(6) * VC_W'(n_s1);
	assign lim         = VC_W'(limit_q);
	assign active      = !stop_eff && !zero_s1;
	assign fill_want   = fr_s1 != '0;
	assign border_want = bw_s1 != '0 && rad_s1 != '0;
	assign fill_fail   = active && fill_want && (vc_eff + n3 > lim);
	assign fill_ok     = active && fill_want && !fill_fail;
	assign vc_a        = fill_ok ? vc_eff + n3 : vc_eff;
	assign border_chk  = active && !fill_fail && border_want;
	assign border_fail = border_chk && (vc_a + n6 > lim);
	assign border_ok   = border_chk && !border_fail;
	assign vc_new      = border_ok ? vc_a + n6 : vc_a;
	assign emit        = fill_ok || border_ok;

	// Retire the held circle once its job is queued or it is dropped
	assign ok           = valid_s1 && (!emit || push_ready);
	assign circle.ready = !valid_s1 || ok;
	assign cfg.ready    = 1'b1;

	assign apex_sum = {{(SUM_W-COORD_W){cx_s1[COORD_W-1]}}, cx_s1}
		+ SUM_W'(fr_s1);

	assign push_valid      = valid_s1 && emit;
	assign push_job.cx     = cx_s1;
	assign push_job.cy     = cy_s1;
	assign push_job.apex   = fill_ok ? sat_coord(apex_sum) : '0;
	assign push_job.fr     = fr_s1;
	assign push_job.rad    = rad_s1;
	assign push_job.n      = n_s1;
	assign push_job.fill   = fill_ok;
	assign push_job.border = border_ok;

	// Hold control state and the vertex limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			vc_q     <= '0;
			stop_q   <= 1'b0;
			limit_q  <= LIMIT_RESET;
		end else begin
			if (cfg.valid) limit_q <= cfg.data;
			if (circle.valid && circle.ready) begin
				valid_s1 <= 1'b1;
			end else if (ok) begin
				valid_s1 <= 1'b0;
			end
			if (ok) begin
				vc_q   <= vc_new;
				stop_q <= stop_eff || fill_fail || border_fail;
			end
		end
	end

	// Capture the circle word
	always_ff @(posedge clk) begin
		if (circle.valid && circle.ready) begin
			fs_s1   <= circle.frame_start;
			cx_s1   <= circle.center_x;
			cy_s1   <= circle.center_y;
			rad_s1  <= circle.radius;
			bw_s1   <= circle.ring_width;
			fr_s1   <= fr_in;
			n_s1    <= n_in;
			zero_s1 <= circle.arc_progress == '0;
		end
	end

endmodule

/* src/crt_queue.sv */
// ----------------------------------------------------------------------------
// crt_queue: short job queue between intake and segment engine
// A small FIFO of circle jobs so either side can stall on its own.
// ----------------------------------------------------------------------------
module crt_queue import crt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign push_ready = cnt_q != QCNT_W'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= bump(wr_q);
			if (do_pop) rd_q <= bump(rd_q);
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_job;
	end

endmodule

/* src/crt_back.sv */
// ----------------------------------------------------------------------------
// crt_back: segment engine
// Walks the segments of each queued circle, one per cycle unless the output
// stalls: table lookup, radius products, then rounding, centering and
// saturation into the output register.
// ----------------------------------------------------------------------------
module crt_back import crt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  job_t         pop_job,
	crt_seg_if.source    seg
);

	logic             act_q;
	job_t             job_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] kn;
	logic             last_k;
	logic             en;

	logic                     valid_s1, valid_s2;
	job_t                     job_s1, job_s2;
	logic                     last_s1, last_s2;
	logic signed [TRIG_W-1:0] c1_s1, s1_s1, c2_s1, s2_s1;
	logic signed [RAD_W:0]    frs, rads;
	logic signed [PROD_W-1:0] pix1_s2, piy1_s2, pix2_s2, piy2_s2;
	logic signed [PROD_W-1:0] pox1_s2, poy1_s2, pox2_s2, poy2_s2;

	assign kn        = k_q + IDX_W'(1);
	assign last_k    = kn == job_q.n;
	assign en        = !seg.valid || seg.ready;
	assign pop_ready = !act_q;
	assign frs       = $signed({1'b0, job_s1.fr});
	assign rads      = $signed({1'b0, job_s1.rad});

	// Hold the active job flag and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= 1'b0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			seg.valid <= 1'b0;
		end else begin
			if (!act_q) begin
				if (pop_valid) act_q <= 1'b1;
			end else if (en && last_k) begin
				act_q <= 1'b0;
			end
			if (en) begin
				valid_s1  <= act_q;
				valid_s2  <= valid_s1;
				seg.valid <= valid_s2;
			end
		end
	end

	// Load a job and step through its segments
	always_ff @(posedge clk) begin
		if (!act_q && pop_valid) begin
			job_q <= pop_job;
			k_q   <= '0;
		end else if (act_q && en) begin
			k_q <= kn;
		end
	end

	// Boundary lookup, products, then final placement
	always_ff @(posedge clk) begin
		if (en && act_q) begin
			c1_s1   <= COS_TAB[k_q];
			s1_s1   <= SIN_TAB[k_q];
			c2_s1   <= COS_TAB[kn];
			s2_s1   <= SIN_TAB[kn];
			job_s1  <= job_q;
			last_s1 <= last_k;
		end
		if (en) begin
			pix1_s2 <= c1_s1 * frs;
			piy1_s2 <= s1_s1 * frs;
			pix2_s2 <= c2_s1 * frs;
			piy2_s2 <= s2_s1 * frs;
			pox1_s2 <= c1_s1 * rads;
			poy1_s2 <= s1_s1 * rads;
			pox2_s2 <= c2_s1 * rads;
			poy2_s2 <= s2_s1 * rads;
			job_s2  <= job_s1;
			last_s2 <= last_s1;

			seg.fan_apex_x <= job_s2.apex;
			seg.inner_x1   <= place(job_s2.cx, pix1_s2);
			seg.inner_y1   <= place(job_s2.cy, piy1_s2);
			seg.inner_x2   <= place(job_s2.cx, pix2_s2);
			seg.inner_y2   <= place(job_s2.cy, piy2_s2);
			seg.outer_x1   <= job_s2.border ? place(job_s2.cx, pox1_s2) : '0;
			seg.outer_y1   <= job_s2.border ? place(job_s2.cy, poy1_s2) : '0;
			seg.outer_x2   <= job_s2.border ? place(job_s2.cx, pox2_s2) : '0;
			seg.outer_y2   <= job_s2.border ? place(job_s2.cy, poy2_s2) : '0;
			seg.has_fill   <= job_s2.fill;
			seg.has_border <= job_s2.border;
			seg.last       <= last_s2;
		end
	end

endmodule

/* src/circle_ring_tessellator_core.sv */
// ----------------------------------------------------------------------------
// circle_ring_tessellator_core: circle to fan and ring segment tessellator
// Top level: intake and budget, job queue, segment engine.
// ----------------------------------------------------------------------------
// Each accepted circle yields n segment words, n = floor(SEGMENTS * progress)
// clamped to 1..SEGMENTS, unless it is dropped by the vertex budget, has
// zero progress or wants neither fill nor border. The intake takes a circle
// every cycle while the two-entry job queue has room; a dropped circle does
// not wait for the queue. The segment engine emits one word per cycle while
// the output is not stalled and takes the next job only after the last
// segment of the current one, so the pace is set by that single engine.
// The vertex limit may be rewritten only while the block is idle.
// ----------------------------------------------------------------------------
module circle_ring_tessellator_core import crt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	crt_circle_if.sink   circle,
	crt_seg_if.source    seg,
	crt_cfg_if.sink      cfg
);

	logic push_valid, push_ready, pop_valid, pop_ready;
	job_t push_job, pop_job;

	crt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.circle     (circle),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	crt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	crt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.seg       (seg)
	);

endmodule

/* src/crt_checker.sv */
// ----------------------------------------------------------------------------
// crt_checker: port-level checks of the segment output
// Output hold under stall and consistency of flags with zeroed fields.
// ----------------------------------------------------------------------------
module crt_checker import crt_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      seg_valid,
	input logic                      seg_ready,
	input logic signed [COORD_W-1:0] fan_apex_x,
	input logic signed [COORD_W-1:0] outer_x1,
	input logic signed [COORD_W-1:0] outer_y1,
	input logic signed [COORD_W-1:0] outer_x2,
	input logic signed [COORD_W-1:0] outer_y2,
	input logic                      has_fill,
	input logic                      has_border,
	input logic                      last
);

	// A stalled word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid && $stable(fan_apex_x) && $stable(last))
		else $error("segment word changed under stall");

	// Every word carries at least one part
	a_part: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> has_fill || has_border)
		else $error("segment word with no part");

	// No fill means a zero apex
	a_apex: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !has_fill |-> fan_apex_x == '0)
		else $error("apex set without fill");

	// No border means zero outer points
	a_outer: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !has_border |->
			outer_x1 == '0 && outer_y1 == '0 && outer_x2 == '0 && outer_y2 == '0)
		else $error("outer points set without border");

endmodule

bind circle_ring_tessellator_core crt_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.seg_valid  (seg.valid),
	.seg_ready  (seg.ready),
	.fan_apex_x (seg.fan_apex_x),
	.outer_x1   (seg.outer_x1),
	.outer_y1   (seg.outer_y1),
	.outer_x2   (seg.outer_x2),
	.outer_y2   (seg.outer_y2),
	.has_fill   (seg.has_fill),
	.has_border (seg.has_border),
	.last       (seg.last)
);
